// ----- rtl/ffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit heap allocator
// Header layout, granule geometry, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Geometry in granules of four bytes.
  localparam int unsigned GW      = 11;    // bits of a granule index
  localparam int unsigned SLOTS   = 1025;  // header slots
  localparam int unsigned HDR_G   = 3;     // header size
  localparam int unsigned MINB_G  = 3;     // minimum block size
  localparam int unsigned ARENA_G = 1018;  // heap minus both headers
  localparam int unsigned END_G   = 1021;  // closing header
  localparam int unsigned END_OFF = END_G * 4;

  // One header slot.
  typedef struct packed {
    logic          valid;
    logic          used;
    logic [GW-1:0] nxt;
    logic [GW-1:0] prv;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_ATEST, S_AEVAL, S_AWH, S_ANRD, S_ANWR, S_APOST, S_ALRD, S_ALEV,
    S_FRD, S_FEV, S_FNRD, S_FNEV, S_FMRD, S_FMWR, S_FPRD, S_FPEV,
    S_FQRD, S_FQWR, S_FCW,
    S_FIN
  } state_e;

endpackage

// ----- rtl/ffa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [12:0] request_bytes;
  logic [11:0] block_offset;
  modport source (output valid, mode, request_bytes, block_offset, input ready);
  modport sink   (input valid, mode, request_bytes, block_offset, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] payload_offset;
  logic [12:0] used_bytes;
  logic [12:0] peak_used_bytes;
  modport source (output valid, status, payload_offset, used_bytes, peak_used_bytes,
                  input ready);
  modport sink   (input valid, status, payload_offset, used_bytes, peak_used_bytes,
                  output ready);
endinterface

// ----- rtl/ffa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap manager with coalescing
// A sequencer walks block headers held in one RAM, one header per step.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one word per request: mode 0 allocates request_bytes,
//   mode 1 frees the block at block_offset. rsp_o returns one word per
//   request with status, payload offset and the used and peak byte counts.
//   Requests are handled one at a time; req_i.ready is high only while the
//   sequencer is idle.
//   An allocate reads one header per block tested, and more while the
//   lowest-free pointer advances; a free reads the block and its neighbours.
//   Each step is one header RAM read, whose registered data sets the pace
//   of the walk.
//   After reset a clearing pass writes every header slot, including the first
//   and the closing header; no request is taken meanwhile.
//   Results sit in an output register, so a new request is accepted while a
//   response waits; if the receiver still stalls when the next response is
//   done, the sequencer holds until the output register frees.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
  import ffa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  state_e        state_q, state_d;
  logic [GW-1:0] cnt_q, cnt_d;
  logic [GW-1:0] lf_q, lf_d;
  logic [12:0]   used_q, used_d;
  logic [12:0]   peak_q, peak_d;
  logic          ov_q, ov_d;

  logic [GW-1:0] idx_q, idx_d;
  logic [GW-1:0] size_q, size_d;
  logic [GW-1:0] aux_q, aux_d;
  hdr_t          cur_q, cur_d;
  status_e       stat_q, stat_d;
  logic [11:0]   pay_q, pay_d;
  status_e       ostat_q, ostat_d;
  logic [11:0]   opay_q, opay_d;
  logic [12:0]   oused_q, oused_d;
  logic [12:0]   opeak_q, opeak_d;

  logic            ram_we;
  logic [GW-1:0]   ram_waddr, ram_raddr;
  hdr_t            ram_wdata;
  logic [HDR_W-1:0] ram_rdata;
  hdr_t            rd;

  ffa_ram #(.WIDTH(HDR_W), .DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = hdr_t'(ram_rdata);

  // Request decode.
  logic [13:0]   req_sum;
  logic [11:0]   size_raw;
  logic          alloc_bad;
  logic [GW-1:0] size_clamp;
  logic          free_range;
  logic          free_misal;
  logic [GW-1:0] free_hg;

  assign req_sum    = {1'b0, req_i.request_bytes} + 14'd3;
  assign size_raw   = req_sum[13:2];
  assign alloc_bad  = (req_i.request_bytes == 13'd0) || (size_raw > 12'(ARENA_G));
  assign size_clamp = (size_raw < 12'(MINB_G)) ? GW'(MINB_G) : size_raw[GW-1:0];
  assign free_range = (req_i.block_offset < 12'(HDR_G * 4)) ||
                      (req_i.block_offset >= 12'(END_OFF));
  assign free_misal = (req_i.block_offset[1:0] != 2'b00);
  assign free_hg    = GW'({1'b0, req_i.block_offset[11:2]} - 11'(HDR_G));

  // Walk and fit tests on the header just read.
  logic [11:0] gap;
  logic        walk_go, fit_ok, split;
  logic [GW-1:0] cut;
  logic [12:0] add_n, used_sum;

  assign walk_go  = idx_q < (GW'(ARENA_G) - size_q);
  assign gap      = {1'b0, rd.nxt} - {1'b0, idx_q} - 12'(HDR_G);
  assign fit_ok   = !rd.used && ({1'b0, rd.nxt} >= ({1'b0, idx_q} + 12'(HDR_G))) &&
                    (gap >= {1'b0, size_q});
  assign split    = gap >= ({1'b0, size_q} + 12'(HDR_G + MINB_G));
  assign cut      = idx_q + GW'(HDR_G) + size_q;
  assign add_n    = split ? {size_q + GW'(HDR_G), 2'b00} : {rd.nxt - idx_q, 2'b00};
  assign used_sum = used_q + add_n;

  // Merge tests.
  logic nx_merge, pv_merge, fin_load;

  assign nx_merge = rd.valid && (cur_q.nxt != idx_q) && !rd.used &&
                    (cur_q.nxt != GW'(END_G));
  assign pv_merge = rd.valid && (cur_q.prv != idx_q) && !rd.used;
  assign fin_load = !ov_q || rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (cnt_q == GW'(SLOTS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (req_i.valid) begin
          if (!req_i.mode) begin
            state_d = alloc_bad ? S_FIN : S_ATEST;
          end else begin
            state_d = (free_range || free_misal) ? S_FIN : S_FRD;
          end
        end
      end
      S_ATEST: state_d = walk_go ? S_AEVAL : S_FIN;
      S_AEVAL: begin
        if (!fit_ok)    state_d = S_ATEST;
        else if (split) state_d = S_AWH;
        else            state_d = S_APOST;
      end
      S_AWH:   state_d = (cur_q.nxt != GW'(END_G)) ? S_ANRD : S_APOST;
      S_ANRD:  state_d = S_ANWR;
      S_ANWR:  state_d = S_APOST;
      S_APOST: state_d = (idx_q == lf_q) ? S_ALRD : S_FIN;
      S_ALRD:  state_d = (lf_q == GW'(END_G)) ? S_FIN : S_ALEV;
      S_ALEV:  state_d = rd.used ? S_ALRD : S_FIN;
      S_FRD:   state_d = S_FEV;
      S_FEV:   state_d = (rd.valid && rd.used) ? S_FNRD : S_FIN;
      S_FNRD:  state_d = S_FNEV;
      S_FNEV:  state_d = nx_merge ? S_FMRD : S_FPRD;
      S_FMRD:  state_d = S_FMWR;
      S_FMWR:  state_d = S_FPRD;
      S_FPRD:  state_d = S_FPEV;
      S_FPEV:  state_d = pv_merge ? S_FQRD : S_FCW;
      S_FQRD:  state_d = S_FQWR;
      S_FQWR:  state_d = S_FCW;
      S_FCW:   state_d = S_FIN;
      S_FIN:   if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    cnt_d     = cnt_q;
    lf_d      = lf_q;
    used_d    = used_q;
    peak_d    = peak_q;
    idx_d     = idx_q;
    size_d    = size_q;
    aux_d     = aux_q;
    cur_d     = cur_q;
    stat_d    = stat_q;
    pay_d     = pay_q;
    ostat_d   = ostat_q;
    opay_d    = opay_q;
    oused_d   = oused_q;
    opeak_d   = opeak_q;
    ov_d      = ov_q && !rsp_o.ready;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = idx_q;
    unique case (state_q)
      // Clearing pass with the first and the closing header.
      S_CLR: begin
        cnt_d     = cnt_q + GW'(1);
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        if (cnt_q == '0) begin
          ram_wdata = '{valid: 1'b1, used: 1'b0, nxt: GW'(END_G), prv: '0};
        end else if (cnt_q == GW'(END_G)) begin
          ram_wdata = '{valid: 1'b1, used: 1'b1, nxt: GW'(END_G), prv: GW'(END_G)};
        end
      end
      S_IDLE: begin
        pay_d  = '0;
        stat_d = ST_OK;
        if (req_i.valid) begin
          if (!req_i.mode) begin
            size_d = size_clamp;
            idx_d  = lf_q;
            if (alloc_bad) stat_d = ST_NOFIT;
          end else begin
            idx_d = free_hg;
            if (free_range)      stat_d = ST_RANGE;
            else if (free_misal) stat_d = ST_NOTALLOC;
          end
        end
      end
      S_ATEST: begin
        ram_raddr = idx_q;
        if (!walk_go) stat_d = ST_NOFIT;
      end
      // Take the block, splitting off the remainder when it is large enough.
      S_AEVAL: begin
        if (fit_ok) begin
          cur_d  = rd;
          pay_d  = 12'({idx_q + GW'(HDR_G), 2'b00});
          stat_d = ST_OK;
          used_d = used_sum;
          if (used_sum > peak_q) peak_d = used_sum;
          ram_we = 1'b1;
          if (split) begin
            aux_d     = cut;
            ram_waddr = cut;
            ram_wdata = '{valid: 1'b1, used: 1'b0, nxt: rd.nxt, prv: idx_q};
          end else begin
            ram_waddr = idx_q;
            ram_wdata = '{valid: 1'b1, used: 1'b1, nxt: rd.nxt, prv: rd.prv};
          end
        end else begin
          idx_d = rd.nxt;
        end
      end
      S_AWH: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '{valid: 1'b1, used: 1'b1, nxt: aux_q, prv: cur_q.prv};
      end
      S_ANRD: ram_raddr = cur_q.nxt;
      S_ANWR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q.nxt;
        ram_wdata = '{valid: rd.valid, used: rd.used, nxt: rd.nxt, prv: aux_q};
      end
      S_APOST: ;
      // Advance the lowest-free pointer past used blocks.
      S_ALRD: ram_raddr = lf_q;
      S_ALEV: if (rd.used) lf_d = rd.nxt;
      S_FRD:  ram_raddr = idx_q;
      S_FEV: begin
        if (rd.valid && rd.used) begin
          cur_d  = '{valid: rd.valid, used: 1'b0, nxt: rd.nxt, prv: rd.prv};
          used_d = used_q - {rd.nxt - idx_q, 2'b00};
          if (idx_q < lf_q) lf_d = idx_q;
        end else begin
          stat_d = ST_NOTALLOC;
        end
      end
      S_FNRD: ram_raddr = cur_q.nxt;
      // Merge with the following free block.
      S_FNEV: begin
        if (nx_merge) begin
          if (lf_q == cur_q.nxt) lf_d = idx_q;
          aux_d     = rd.nxt;
          cur_d.nxt = rd.nxt;
          ram_we    = 1'b1;
          ram_waddr = cur_q.nxt;
          ram_wdata = '{valid: 1'b0, used: rd.used, nxt: rd.nxt, prv: rd.prv};
        end
      end
      S_FMRD: ram_raddr = aux_q;
      S_FMWR: begin
        ram_we    = 1'b1;
        ram_waddr = aux_q;
        ram_wdata = '{valid: rd.valid, used: rd.used, nxt: rd.nxt, prv: idx_q};
      end
      S_FPRD: ram_raddr = cur_q.prv;
      // Merge into the preceding free block.
      S_FPEV: begin
        if (pv_merge) begin
          if (lf_q == idx_q) lf_d = cur_q.prv;
          cur_d.valid = 1'b0;
          ram_we      = 1'b1;
          ram_waddr   = cur_q.prv;
          ram_wdata   = '{valid: rd.valid, used: rd.used, nxt: cur_q.nxt, prv: rd.prv};
        end
      end
      S_FQRD: ram_raddr = cur_q.nxt;
      S_FQWR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q.nxt;
        ram_wdata = '{valid: rd.valid, used: rd.used, nxt: rd.nxt, prv: cur_q.prv};
      end
      S_FCW: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = cur_q;
      end
      // Hand the result to the output register.
      S_FIN: begin
        if (fin_load) begin
          ov_d    = 1'b1;
          ostat_d = stat_q;
          opay_d  = pay_q;
          oused_d = used_q;
          opeak_d = peak_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      lf_q    <= '0;
      used_q  <= '0;
      peak_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lf_q    <= lf_d;
      used_q  <= used_d;
      peak_q  <= peak_d;
      ov_q    <= ov_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    size_q  <= size_d;
    aux_q   <= aux_d;
    cur_q   <= cur_d;
    stat_q  <= stat_d;
    pay_q   <= pay_d;
    ostat_q <= ostat_d;
    opay_q  <= opay_d;
    oused_q <= oused_d;
    opeak_q <= opeak_d;
  end

  assign req_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = ov_q;
  assign rsp_o.status          = ostat_q;
  assign rsp_o.payload_offset  = opay_q;
  assign rsp_o.used_bytes      = oused_q;
  assign rsp_o.peak_used_bytes = opeak_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for first_fit_heap_allocator
// Drives allocate and free words with random gaps and a random receiver stall.
// A block-chain model predicts the status, the payload offset and the counts.
// Each response word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
  import ffa_pkg::*;
();

  localparam int unsigned HB      = 12;    // header bytes
  localparam int unsigned MB      = 12;    // minimum block bytes
  localparam int unsigned ARENA_B = 4072;  // heap minus both headers
  localparam int unsigned END_B   = 4084;  // closing header offset
  localparam int unsigned NSLOT   = 1025;
  localparam int unsigned N_RAND  = 830;
  localparam int unsigned LIMIT   = 4000000;

  typedef enum bit {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_e;

  typedef struct {
    status_e     status;
    logic [11:0] payload;
    logic [12:0] used;
    logic [12:0] peak;
  } heap_word_t;

  typedef struct {
    bit          valid;
    bit          used;
    int unsigned nxt;
    int unsigned prv;
  } block_hdr_t;

  // Block-chain model of the heap and the queue of predicted words.
  class heap_scoreboard;
    block_hdr_t  chain[NSLOT];
    int unsigned low_free;
    int unsigned in_use;
    int unsigned peak;
    heap_word_t  pending[$];
    int unsigned errors;
    int unsigned last_payload;

    function int unsigned slot(int unsigned off);
      int unsigned i;
      i = off / 4;
      if (i >= NSLOT) i = NSLOT - 1;
      return i;
    endfunction

    function void clear_heap();
      foreach (chain[i]) chain[i] = '{0, 0, 0, 0};
      chain[0] = '{1, 0, END_B, 0};
      chain[slot(END_B)] = '{1, 1, END_B, END_B};
      low_free = 0;
      in_use = 0;
      peak = 0;
      errors = 0;
    endfunction

    function void grow(int unsigned n);
      in_use = (in_use + n) & 20'hFFFFF;
      if (peak < in_use) peak = in_use;
    endfunction

    function status_e allocate(int unsigned req, output int unsigned pay);
      int unsigned size, idx, guard, cut, g, span;
      pay = 0;
      if (req == 0) return ST_NOFIT;
      size = (req + 3) / 4 * 4;
      if (size > ARENA_B) return ST_NOFIT;
      if (size < MB) size = MB;
      idx = low_free;
      for (guard = 0; idx < ARENA_B - size && guard < NSLOT; guard++) begin
        span = chain[slot(idx)].nxt - idx - HB;
        if (!chain[slot(idx)].used && chain[slot(idx)].nxt >= idx + HB && span >= size) begin
          if (span >= size + HB + MB) begin
            // Split: the remainder becomes a new free block.
            cut = idx + HB + size;
            chain[slot(cut)] = '{1, 0, chain[slot(idx)].nxt, idx};
            chain[slot(idx)].nxt = cut;
            chain[slot(idx)].used = 1;
            if (chain[slot(cut)].nxt != END_B) chain[slot(chain[slot(cut)].nxt)].prv = cut;
            grow(size + HB);
          end else begin
            chain[slot(idx)].used = 1;
            grow(chain[slot(idx)].nxt - idx);
          end
          chain[slot(idx)].valid = 1;
          if (idx == low_free) begin
            for (g = 0; g < NSLOT; g++) begin
              if (!chain[slot(low_free)].used || low_free == END_B) break;
              low_free = chain[slot(low_free)].nxt;
            end
          end
          pay = idx + HB;
          return ST_OK;
        end
        idx = chain[slot(idx)].nxt;
      end
      return ST_NOFIT;
    endfunction

    function void coalesce(int unsigned h);
      int unsigned nx, pv;
      nx = chain[slot(h)].nxt;
      if (chain[slot(nx)].valid && nx != h && !chain[slot(nx)].used && nx != END_B) begin
        if (low_free == nx) low_free = h;
        chain[slot(h)].nxt = chain[slot(nx)].nxt;
        chain[slot(chain[slot(nx)].nxt)].prv = h;
        chain[slot(nx)].valid = 0;
      end
      pv = chain[slot(h)].prv;
      if (chain[slot(pv)].valid && pv != h && !chain[slot(pv)].used) begin
        if (low_free == h) low_free = pv;
        chain[slot(pv)].nxt = chain[slot(h)].nxt;
        chain[slot(chain[slot(h)].nxt)].prv = pv;
        chain[slot(h)].valid = 0;
      end
    endfunction

    function status_e release_block(int unsigned p);
      int unsigned h;
      if (p < HB || p >= END_B) return ST_RANGE;
      h = p - HB;
      if (h % 4 != 0) return ST_NOTALLOC;
      if (!chain[slot(h)].valid || !chain[slot(h)].used) return ST_NOTALLOC;
      chain[slot(h)].used = 0;
      if (h < low_free) low_free = h;
      in_use = (in_use - (chain[slot(h)].nxt - h)) & 20'hFFFFF;
      coalesce(h);
      return ST_OK;
    endfunction

    // Notes an accepted request word and predicts its response word.
    function void note_request(op_e op, int unsigned req, int unsigned off);
      heap_word_t w;
      int unsigned pay;
      pay = 0;
      if (op == OP_ALLOC) w.status = allocate(req, pay);
      else w.status = release_block(off);
      last_payload = pay;
      w.payload = pay[11:0];
      w.used = in_use[12:0];
      w.peak = peak[12:0];
      pending.push_back(w);
    endfunction

    // Checks a response word against the oldest prediction.
    function void check_result(logic [1:0] st, logic [11:0] po, logic [12:0] ub,
                               logic [12:0] pk);
      heap_word_t w;
      if (pending.size() == 0) begin
        $error("response word with no request pending");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, st); errors++;
      end
      if (po !== w.payload) begin
        $error("payload_offset: expected %0d, got %0d", w.payload, po); errors++;
      end
      if (ub !== w.used) begin
        $error("used_bytes: expected %0d, got %0d", w.used, ub); errors++;
      end
      if (pk !== w.peak) begin
        $error("peak_used_bytes: expected %0d, got %0d", w.peak, pk); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  ffa_req_if   req_if ();
  ffa_rsp_if   rsp_if ();
  heap_scoreboard sb;
  int unsigned cycles;
  int unsigned live[$];

  first_fit_heap_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Cycle counter and run-time limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("first_fit_heap_allocator verification failed");
      $finish;
    end
  end

  // Sends one request word; before most words valid drops for a random gap, else it stays high.
  task automatic send_word(op_e op, int unsigned req, int unsigned off);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= op;
    req_if.request_bytes <= req[12:0];
    req_if.block_offset  <= off[11:0];
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, req, off);
    if (op == OP_ALLOC && sb.pending[$].status == ST_OK) live.push_back(sb.last_payload);
  endtask

  task automatic alloc_word(int unsigned req);
    send_word(OP_ALLOC, req, $urandom_range(0, 4095));
  endtask

  task automatic free_word(int unsigned off);
    int unsigned k;
    send_word(OP_FREE, $urandom_range(0, 4096), off);
    for (k = 0; k < live.size(); k++) begin
      if (live[k] == off && sb.pending[$].status == ST_OK) begin
        live.delete(k);
        break;
      end
    end
  endtask

  // Receiver with random stalls and stretches of steady readiness.
  initial begin
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_result(rsp_if.status, rsp_if.payload_offset, rsp_if.used_bytes,
                      rsp_if.peak_used_bytes);
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned p_a, p_b, p_c, p_d, n, pick, sz;
    sb = new();
    sb.clear_heap();
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode <= OP_ALLOC;
    req_if.request_bytes <= '0;
    req_if.block_offset <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero and oversize requests, the top of the arena, bad frees.
    alloc_word(0);
    alloc_word(4096);
    alloc_word(ARENA_B);
    alloc_word(ARENA_B - 3);
    alloc_word(ARENA_B - 4);
    free_word(HB);
    alloc_word(1);    p_a = sb.last_payload;
    alloc_word(5);    p_b = sb.last_payload;
    alloc_word(13);   p_c = sb.last_payload;
    alloc_word(100);  p_d = sb.last_payload;
    free_word(0);
    free_word(HB - 1);
    free_word(END_B);
    free_word(4095);
    free_word(HB + 1);
    free_word(200);
    // Merges with the previous, then the next neighbour; then stale frees.
    free_word(p_b);
    free_word(p_c);
    free_word(p_a);
    free_word(p_a);
    free_word(p_b);
    free_word(p_d);

    // Random: mostly well-formed alloc/free traffic, some broken frees.
    for (n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 2) begin
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50 || (live.size() < 4 && pick < 85)) begin
        sz = $urandom_range(0, 99);
        if (sz < 70) alloc_word($urandom_range(1, 64));
        else if (sz < 95) alloc_word($urandom_range(65, 512));
        else alloc_word($urandom_range(0, 4096));
      end else if (pick < 88 && live.size() > 0) begin
        free_word(live[$urandom_range(0, live.size() - 1)]);
      end else begin
        free_word($urandom_range(0, 4095));
      end
    end
    req_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("first_fit_heap_allocator verification clean");
    end else begin
      $display("first_fit_heap_allocator verification failed");
    end
    $finish;
  end

endmodule
